@@ hw/rtl/ipv4_prefix_trie_lookup_core_defines.svh @@
// assertion helpers used by the checker file
`ifndef IPV4_PREFIX_TRIE_LOOKUP_CORE_DEFINES_SVH
`define IPV4_PREFIX_TRIE_LOOKUP_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define IPTL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define IPTL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/iptl_pkg.sv @@
`default_nettype none

package iptl_pkg;

    localparam int NODE_COUNT_DEF = 4096;
    localparam int ADDR_W         = 32;
    localparam int LEN_W          = 6;
    localparam int TAG_W          = 56;
    localparam int TAG_BYTES      = 7;

    localparam logic [LEN_W-1:0] MAX_DEPTH = 6'd32;
    localparam logic [TAG_W-1:0] ROOT_TAG  = 56'h2A2A2A;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_LINK,
        ST_ALLOC,
        ST_DONE
    } state_t;

    // write enables into the node store
    typedef struct packed {
        logic zc;
        logic oc;
        logic tag;
    } mem_we_t;

    // keep bytes up to the first zero byte
    function automatic logic [TAG_W-1:0] clip_tag(input logic [TAG_W-1:0] t);
        logic [TAG_W-1:0] r;
        logic             live;
        r    = '0;
        live = 1'b1;
        for (int k = 0; k < TAG_BYTES; k++)
        begin
            if (t[8*k +: 8] == 8'd0)
                live = 1'b0;
            if (live)
                r[8*k +: 8] = t[8*k +: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/iptl_node_mem.sv @@
`default_nettype none

module iptl_node_mem #(
    parameter int NODE_COUNT = iptl_pkg::NODE_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire iptl_pkg::mem_we_t             we,
    input  wire logic [$clog2(NODE_COUNT)-1:0] wr_addr,
    input  wire logic [$clog2(NODE_COUNT)-1:0] wr_zc,
    input  wire logic [$clog2(NODE_COUNT)-1:0] wr_oc,
    input  wire logic [iptl_pkg::TAG_W-1:0]    wr_tag,
    input  wire logic [$clog2(NODE_COUNT)-1:0] rd_addr,
    output logic      [$clog2(NODE_COUNT)-1:0] rd_zc,
    output logic      [$clog2(NODE_COUNT)-1:0] rd_oc,
    output logic      [iptl_pkg::TAG_W-1:0]    rd_tag
);

    localparam int IDX_W = $clog2(NODE_COUNT);

    logic [IDX_W-1:0]           zc_mem  [NODE_COUNT];
    logic [IDX_W-1:0]           oc_mem  [NODE_COUNT];
    logic [iptl_pkg::TAG_W-1:0] tag_mem [NODE_COUNT];

    always_ff @(posedge clk)
    begin
        if (we.zc)
            zc_mem[wr_addr] <= wr_zc;
        if (we.oc)
            oc_mem[wr_addr] <= wr_oc;
        if (we.tag)
            tag_mem[wr_addr] <= wr_tag;
    end

    always_ff @(posedge clk)
    begin
        rd_zc  <= zc_mem[rd_addr];
        rd_oc  <= oc_mem[rd_addr];
        rd_tag <= tag_mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/iptl_walker.sv @@
`default_nettype none

module iptl_walker #(
    parameter int NODE_COUNT = iptl_pkg::NODE_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          operation,
    input  wire logic [iptl_pkg::ADDR_W-1:0]   address,
    input  wire logic [iptl_pkg::LEN_W-1:0]    prefix_len,
    input  wire logic [iptl_pkg::TAG_W-1:0]    tag_in,
    output logic                               busy,
    output logic                               done,
    output logic      [iptl_pkg::TAG_W-1:0]    tag_out,
    output logic      [iptl_pkg::LEN_W-1:0]    match_len,
    output logic                               status,
    output iptl_pkg::mem_we_t                  mem_we,
    output logic      [$clog2(NODE_COUNT)-1:0] wr_addr,
    output logic      [$clog2(NODE_COUNT)-1:0] wr_zc,
    output logic      [$clog2(NODE_COUNT)-1:0] wr_oc,
    output logic      [iptl_pkg::TAG_W-1:0]    wr_tag,
    output logic      [$clog2(NODE_COUNT)-1:0] rd_addr,
    input  wire logic [$clog2(NODE_COUNT)-1:0] rd_zc,
    input  wire logic [$clog2(NODE_COUNT)-1:0] rd_oc,
    input  wire logic [iptl_pkg::TAG_W-1:0]    rd_tag
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(NODE_COUNT + 1);
    localparam int AW    = iptl_pkg::ADDR_W;
    localparam int LW    = iptl_pkg::LEN_W;
    localparam int TW    = iptl_pkg::TAG_W;

    iptl_pkg::state_t state_reg, state_next;

    logic             op_reg,        op_next;
    logic [AW-1:0]    addr_reg,      addr_next;
    logic [LW-1:0]    len_reg,       len_next;
    logic [TW-1:0]    tag_reg,       tag_next;
    logic [IDX_W-1:0] node_reg,      node_next;
    logic [LW-1:0]    depth_reg,     depth_next;
    logic [CNT_W-1:0] used_reg,      used_next;
    logic [IDX_W-1:0] root_zc_reg,   root_zc_next;
    logic [IDX_W-1:0] root_oc_reg,   root_oc_next;
    logic [TW-1:0]    best_reg,      best_next;
    logic [LW-1:0]    best_len_reg,  best_len_next;
    logic             status_reg,    status_next;

    logic             is_root;
    logic [IDX_W-1:0] cur_zc;
    logic [IDX_W-1:0] cur_oc;
    logic [TW-1:0]    cur_tag;
    logic             cur_bit;
    logic [IDX_W-1:0] child;
    logic             child_none;
    logic             cur_tagged;
    logic [CNT_W-1:0] free_cnt;
    logic [LW-1:0]    missing;
    logic             pool_short;
    logic [IDX_W-1:0] new_node;
    logic [IDX_W-1:0] new_node_succ;
    logic             at_end;
    logic             lookup_stop;
    logic             start_ok;
    logic [LW-1:0]    len_sat;

    // root links live in flops, the root tag is fixed
    assign is_root    = (node_reg == '0);
    assign cur_zc     = is_root ? root_zc_reg : rd_zc;
    assign cur_oc     = is_root ? root_oc_reg : rd_oc;
    assign cur_tag    = is_root ? iptl_pkg::ROOT_TAG : rd_tag;
    assign cur_bit    = addr_reg[AW-1];
    assign child      = cur_bit ? cur_oc : cur_zc;
    assign child_none = (child == '0);
    assign cur_tagged = (cur_tag[7:0] != 8'd0);

    assign free_cnt      = CNT_W'(NODE_COUNT) - used_reg;
    assign missing       = len_reg - depth_reg;
    assign pool_short    = (CNT_W'(missing) > free_cnt);
    assign new_node      = used_reg[IDX_W-1:0];
    assign new_node_succ = new_node + IDX_W'(1);
    assign at_end        = (depth_reg == len_reg);
    assign lookup_stop   = (depth_reg == iptl_pkg::MAX_DEPTH) || child_none;

    assign start_ok = start && (state_reg == iptl_pkg::ST_IDLE);
    assign len_sat  = (prefix_len > iptl_pkg::MAX_DEPTH) ? iptl_pkg::MAX_DEPTH : prefix_len;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iptl_pkg::ST_IDLE:
            begin
                if (start_ok)
                begin
                    if (operation == iptl_pkg::OP_INSERT && prefix_len == '0)
                        state_next = iptl_pkg::ST_DONE;
                    else
                        state_next = iptl_pkg::ST_WALK;
                end
            end
            iptl_pkg::ST_WALK:
            begin
                if (op_reg == iptl_pkg::OP_LOOKUP)
                begin
                    if (lookup_stop)
                        state_next = iptl_pkg::ST_DONE;
                end
                else if (at_end)
                    state_next = iptl_pkg::ST_DONE;
                else if (child_none)
                    state_next = pool_short ? iptl_pkg::ST_DONE : iptl_pkg::ST_LINK;
            end
            iptl_pkg::ST_LINK:
                state_next = iptl_pkg::ST_ALLOC;
            iptl_pkg::ST_ALLOC:
            begin
                if (at_end)
                    state_next = iptl_pkg::ST_DONE;
            end
            iptl_pkg::ST_DONE:
                state_next = iptl_pkg::ST_IDLE;
            default:
                state_next = iptl_pkg::ST_IDLE;
        endcase
    end

    // datapath and node store controls
    always_comb
    begin
        op_next       = op_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        tag_next      = tag_reg;
        node_next     = node_reg;
        depth_next    = depth_reg;
        used_next     = used_reg;
        root_zc_next  = root_zc_reg;
        root_oc_next  = root_oc_reg;
        best_next     = best_reg;
        best_len_next = best_len_reg;
        status_next   = status_reg;
        mem_we        = '0;
        wr_addr       = node_reg;
        wr_zc         = '0;
        wr_oc         = '0;
        wr_tag        = '0;

        case (state_reg)
            iptl_pkg::ST_IDLE:
            begin
                if (start_ok)
                begin
                    op_next       = operation;
                    addr_next     = address;
                    len_next      = len_sat;
                    tag_next      = iptl_pkg::clip_tag(tag_in);
                    node_next     = '0;
                    depth_next    = '0;
                    best_next     = '0;
                    best_len_next = '0;
                    status_next   = iptl_pkg::STAT_OK;
                end
            end
            iptl_pkg::ST_WALK:
            begin
                if (op_reg == iptl_pkg::OP_LOOKUP)
                begin
                    if (cur_tagged)
                    begin
                        best_next     = cur_tag;
                        best_len_next = depth_reg;
                    end
                    if (!lookup_stop)
                    begin
                        node_next  = child;
                        depth_next = depth_reg + LW'(1);
                        addr_next  = addr_reg << 1;
                    end
                end
                else if (at_end)
                begin
                    // whole path exists, first writer wins
                    if (!cur_tagged)
                    begin
                        mem_we.tag = 1'b1;
                        wr_tag     = tag_reg;
                    end
                end
                else if (child_none)
                begin
                    if (pool_short)
                        status_next = iptl_pkg::STAT_FULL;
                end
                else
                begin
                    node_next  = child;
                    depth_next = depth_reg + LW'(1);
                    addr_next  = addr_reg << 1;
                end
            end
            iptl_pkg::ST_LINK:
            begin
                // hook the first new node under the last existing one
                if (is_root)
                begin
                    if (cur_bit)
                        root_oc_next = new_node;
                    else
                        root_zc_next = new_node;
                end
                else if (cur_bit)
                begin
                    mem_we.oc = 1'b1;
                    wr_oc     = new_node;
                end
                else
                begin
                    mem_we.zc = 1'b1;
                    wr_zc     = new_node;
                end
                depth_next = depth_reg + LW'(1);
                addr_next  = addr_reg << 1;
            end
            iptl_pkg::ST_ALLOC:
            begin
                // new nodes form a chain with consecutive indexes
                mem_we  = '{zc: 1'b1, oc: 1'b1, tag: 1'b1};
                wr_addr = new_node;
                if (at_end)
                    wr_tag = tag_reg;
                else if (cur_bit)
                    wr_oc = new_node_succ;
                else
                    wr_zc = new_node_succ;
                used_next = used_reg + CNT_W'(1);
                if (!at_end)
                begin
                    depth_next = depth_reg + LW'(1);
                    addr_next  = addr_reg << 1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rd_addr = node_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= iptl_pkg::ST_IDLE;
            used_reg    <= CNT_W'(1);
            root_zc_reg <= '0;
            root_oc_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            root_zc_reg <= root_zc_next;
            root_oc_reg <= root_oc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        tag_reg      <= tag_next;
        node_reg     <= node_next;
        depth_reg    <= depth_next;
        best_reg     <= best_next;
        best_len_reg <= best_len_next;
        status_reg   <= status_next;
    end

    assign busy      = (state_reg != iptl_pkg::ST_IDLE);
    assign done      = (state_reg == iptl_pkg::ST_DONE);
    assign tag_out   = best_reg;
    assign match_len = best_len_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ipv4_prefix_trie_lookup_core.sv @@
// Longest-prefix-match trie over IPv4 addresses with 7-byte tags. An item is taken when
// start is high and busy is low; its result is shown for exactly one cycle with done high,
// and the receiver cannot stall it, so it must sample on that cycle. One trie level is
// walked per clock through a single node store read port. An insert walks the existing
// path; where nodes are added, it links the new branch and then writes the new nodes one
// by one. An insert of length 0 skips the walk and goes straight to done. The node store
// needs no clearing pass after reset: nodes are written as they are taken from the pool
// and the root lives in flops. When the pool is short, status reports it and the trie is
// left unchanged.
`default_nettype none

module ipv4_prefix_trie_lookup_core #(
    parameter int NODE_COUNT = iptl_pkg::NODE_COUNT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        operation,
    input  wire logic [iptl_pkg::ADDR_W-1:0] address,
    input  wire logic [iptl_pkg::LEN_W-1:0]  prefix_len,
    input  wire logic [iptl_pkg::TAG_W-1:0]  tag_in,
    output logic                             done,
    output logic      [iptl_pkg::TAG_W-1:0]  tag_out,
    output logic      [iptl_pkg::LEN_W-1:0]  match_len,
    output logic                             status
);

    localparam int IDX_W = $clog2(NODE_COUNT);

    iptl_pkg::mem_we_t          mem_we;
    logic [IDX_W-1:0]           wr_addr;
    logic [IDX_W-1:0]           wr_zc;
    logic [IDX_W-1:0]           wr_oc;
    logic [iptl_pkg::TAG_W-1:0] wr_tag;
    logic [IDX_W-1:0]           rd_addr;
    logic [IDX_W-1:0]           rd_zc;
    logic [IDX_W-1:0]           rd_oc;
    logic [iptl_pkg::TAG_W-1:0] rd_tag;

    iptl_walker #(
        .NODE_COUNT (NODE_COUNT)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operation  (operation),
        .address    (address),
        .prefix_len (prefix_len),
        .tag_in     (tag_in),
        .busy       (busy),
        .done       (done),
        .tag_out    (tag_out),
        .match_len  (match_len),
        .status     (status),
        .mem_we     (mem_we),
        .wr_addr    (wr_addr),
        .wr_zc      (wr_zc),
        .wr_oc      (wr_oc),
        .wr_tag     (wr_tag),
        .rd_addr    (rd_addr),
        .rd_zc      (rd_zc),
        .rd_oc      (rd_oc),
        .rd_tag     (rd_tag)
    );

    iptl_node_mem #(
        .NODE_COUNT (NODE_COUNT)
    ) u_node_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wr_addr),
        .wr_zc   (wr_zc),
        .wr_oc   (wr_oc),
        .wr_tag  (wr_tag),
        .rd_addr (rd_addr),
        .rd_zc   (rd_zc),
        .rd_oc   (rd_oc),
        .rd_tag  (rd_tag)
    );

endmodule

`default_nettype wire

@@ hw/rtl/iptl_checker.sv @@
`default_nettype none

`include "ipv4_prefix_trie_lookup_core_defines.svh"

module iptl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [55:0] tag_out,
    input wire logic [5:0]  match_len,
    input wire logic        status
);

    // a result only shows up while an item is in flight
    `IPTL_ASSERT_IMP(a_done_busy, done, busy, "done without busy")

    `IPTL_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

    `IPTL_ASSERT_NXT(a_done_pulse, done, !done && !busy, "result not a single-cycle pulse")

    // a pool-full insert never carries a tag or a length
    `IPTL_ASSERT_IMP(a_full_clean, done && status, tag_out == 56'd0 && match_len == 6'd0,
        "pool-full result carries match data")

    `IPTL_ASSERT_IMP(a_len_range, done, match_len <= 6'd32, "match length beyond 32")

endmodule

bind ipv4_prefix_trie_lookup_core iptl_checker u_iptl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .tag_out   (tag_out),
    .match_len (match_len),
    .status    (status)
);

`default_nettype wire
